FILE: hw/rtl/lstlm_pkg.sv
// Package for the LFO step timer light mixer: widths, codes, register
// reset values and the shared types. No dependencies.
package lstlm_pkg;

	localparam int MAX_STEPS_PER_TICK = 4;
	localparam int TICK_INCREMENT     = 255;

	localparam int ACCUM_W   = 32;
	localparam int US_W      = 24;
	localparam int STEP_W    = 8;
	localparam int SAMPLE_W  = 8;
	localparam int WEIGHT_W  = 6;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;
	localparam int STORE_DEPTH = 1 << STEP_W;
	localparam int STEP_CNT_W  = $clog2(MAX_STEPS_PER_TICK + 1);

	localparam int MUL_X_W = 11;
	localparam int MUL_Y_W = 7;
	localparam int PROD_W  = MUL_X_W + MUL_Y_W;
	localparam int FRAC_W  = 5;
	localparam int MAC_W   = PROD_W - FRAC_W;

	localparam int WEIGHT_ONE = 32;
	localparam int FULL_LEVEL = 255;
	localparam int US_TO_TICK_SHIFT = 3;
	localparam int HALF_BIT = STEP_W - 1;

	localparam logic [US_W-1:0]     FIRST_HALF_RST  = 24'd784;
	localparam logic [US_W-1:0]     SECOND_HALF_RST = 24'd784;
	localparam logic [STEP_W-1:0]   PHASE_RST       = '0;
	localparam logic                INVERT_RST      = 1'b0;
	localparam logic [WEIGHT_W-1:0] HIGH_MIX_RST    = 6'd32;
	localparam logic [WEIGHT_W-1:0] LOW_MIX_RST     = 6'd32;
	localparam logic [SAMPLE_W-1:0] TARGET_RST      = '0;
	localparam logic [WEIGHT_W-1:0] DEPTH_RST       = 6'd32;

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 2'd0,
		OP_EXT_CLK  = 2'd1,
		OP_TABLE_WR = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_HALF_US  = 3'd0,
		REG_SECOND_HALF_US = 3'd1,
		REG_PHASE_OFFSET   = 3'd2,
		REG_INVERT         = 3'd3,
		REG_HIGH_MIX       = 3'd4,
		REG_LOW_MIX        = 3'd5,
		REG_MIX_TARGET     = 3'd6,
		REG_DEPTH          = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [US_W-1:0]     first_half_us;
		logic [US_W-1:0]     second_half_us;
		logic [STEP_W-1:0]   phase_offset;
		logic                invert;
		logic [WEIGHT_W-1:0] high_mix;
		logic [WEIGHT_W-1:0] low_mix;
		logic [SAMPLE_W-1:0] mix_target;
		logic [WEIGHT_W-1:0] depth;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic clear;
	} alu_ctrl_t;

	typedef logic signed [MUL_X_W-1:0] mul_x_t;
	typedef logic signed [MUL_Y_W-1:0] mul_y_t;
	typedef logic signed [MAC_W-1:0]   mac_t;

endpackage

FILE: hw/rtl/lstlm_if.sv
// Channel interfaces of the LFO step timer light mixer: command, light
// result and configuration write. Depends on lstlm_pkg.
interface lstlm_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [lstlm_pkg::OP_W-1:0]       op;
	logic [lstlm_pkg::STEP_W-1:0]     table_address;
	logic [lstlm_pkg::SAMPLE_W-1:0]   table_value;
	modport source (output valid, output op, output table_address, output table_value,
		input ready);
	modport sink (input valid, input op, input table_address, input table_value,
		output ready);
endinterface

interface lstlm_light_if;
	logic                           valid;
	logic                           ready;
	logic [lstlm_pkg::STEP_W-1:0]   step_index;
	logic [lstlm_pkg::SAMPLE_W-1:0] high_light;
	logic [lstlm_pkg::SAMPLE_W-1:0] low_light;
	logic                           last;
	modport source (output valid, output step_index, output high_light, output low_light,
		output last, input ready);
	modport sink (input valid, input step_index, input high_light, input low_light,
		input last, output ready);
endinterface

interface lstlm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lstlm_pkg::CFG_IDX_W-1:0] index;
	logic [lstlm_pkg::CFG_DAT_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/lstlm_cfg_regs.sv
// Configuration register file of the LFO step timer light mixer.
// Depends on lstlm_pkg and lstlm_cfg_if.
module lstlm_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	lstlm_cfg_if.sink         cfg,
	output lstlm_pkg::cfg_t   regs
);

	lstlm_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.first_half_us  <= lstlm_pkg::FIRST_HALF_RST;
			regs_q.second_half_us <= lstlm_pkg::SECOND_HALF_RST;
			regs_q.phase_offset   <= lstlm_pkg::PHASE_RST;
			regs_q.invert         <= lstlm_pkg::INVERT_RST;
			regs_q.high_mix       <= lstlm_pkg::HIGH_MIX_RST;
			regs_q.low_mix        <= lstlm_pkg::LOW_MIX_RST;
			regs_q.mix_target     <= lstlm_pkg::TARGET_RST;
			regs_q.depth          <= lstlm_pkg::DEPTH_RST;
		end else if (cfg.valid) begin
			unique case (lstlm_pkg::reg_idx_t'(cfg.index))
				lstlm_pkg::REG_FIRST_HALF_US:  regs_q.first_half_us  <= cfg.data;
				lstlm_pkg::REG_SECOND_HALF_US: regs_q.second_half_us <= cfg.data;
				lstlm_pkg::REG_PHASE_OFFSET:
					regs_q.phase_offset <= cfg.data[lstlm_pkg::STEP_W-1:0];
				lstlm_pkg::REG_INVERT:         regs_q.invert <= cfg.data[0];
				lstlm_pkg::REG_HIGH_MIX:
					regs_q.high_mix <= cfg.data[lstlm_pkg::WEIGHT_W-1:0];
				lstlm_pkg::REG_LOW_MIX:
					regs_q.low_mix <= cfg.data[lstlm_pkg::WEIGHT_W-1:0];
				lstlm_pkg::REG_MIX_TARGET:
					regs_q.mix_target <= cfg.data[lstlm_pkg::SAMPLE_W-1:0];
				lstlm_pkg::REG_DEPTH:
					regs_q.depth <= cfg.data[lstlm_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hw/rtl/lstlm_alu.sv
// Shared signed multiply-accumulate unit: acc += trunc(x*y / 32), or
// acc = trunc(x*y / 32) when clear is set. Depends on lstlm_pkg.
module lstlm_alu (
	input  logic                  clk,
	input  lstlm_pkg::alu_ctrl_t  ctrl,
	input  lstlm_pkg::mul_x_t     x,
	input  lstlm_pkg::mul_y_t     y,
	output lstlm_pkg::mac_t       acc
);

	logic signed [lstlm_pkg::PROD_W-1:0] prod;
	logic        [lstlm_pkg::PROD_W-1:0] prod_adj;
	lstlm_pkg::mac_t                     quot;
	lstlm_pkg::mac_t                     base;
	lstlm_pkg::mac_t                     acc_q;

	// truncate toward zero: bias negative products by 31 before the shift
	always_comb begin
		prod     = x * y;
		prod_adj = prod + {{(lstlm_pkg::PROD_W - lstlm_pkg::FRAC_W){1'b0}},
			{lstlm_pkg::FRAC_W{prod[lstlm_pkg::PROD_W-1]}}};
		quot     = prod_adj[lstlm_pkg::PROD_W-1:lstlm_pkg::FRAC_W];
		base     = ctrl.clear ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= base + quot;
		end
	end

	assign acc = acc_q;

endmodule

FILE: hw/rtl/lfo_step_timer_light_mixer.sv
// LFO step timer light mixer, top level: sequencer, tick accumulator,
// waveform store and result register. Depends on lstlm_pkg, lstlm_if,
// lstlm_cfg_regs and lstlm_alu.
//
// A table write is done as the command is accepted in S_IDLE. An external
// clock step passes S_RDH, S_RDL, S_MIX and S_EMIT before its light request
// is offered; a timer tick passes S_CHECK and then makes up to 4 such steps.
// Each step reads the single-port waveform store in S_RDH and S_RDL, then
// uses the shared multiply-accumulate unit in S_MIX, four products per light
// level. The command channel is ready only between items; a finished light
// request waits in the output register while the next command is accepted.
module lfo_step_timer_light_mixer (
	input  logic          clk,
	input  logic          arst_n,
	lstlm_cmd_if.sink     cmd,
	lstlm_light_if.source light,
	lstlm_cfg_if.sink     cfg
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_RDH,
		S_RDL,
		S_MIX,
		S_EMIT
	} state_t;

	state_t                               state_q;
	logic [lstlm_pkg::ACCUM_W-1:0]        tick_acc_q;
	logic [lstlm_pkg::STEP_W-1:0]         step_q;
	logic [lstlm_pkg::STEP_CNT_W-1:0]     nsteps_q;
	logic                                 ext_q;
	logic [2:0]                           phase_q;
	logic [lstlm_pkg::SAMPLE_W-1:0]       high_q;

	logic                                 out_valid_q;
	logic [lstlm_pkg::STEP_W-1:0]         out_step_q;
	logic [lstlm_pkg::SAMPLE_W-1:0]       out_high_q;
	logic [lstlm_pkg::SAMPLE_W-1:0]       out_low_q;
	logic                                 out_last_q;

	logic [lstlm_pkg::SAMPLE_W-1:0]       store [lstlm_pkg::STORE_DEPTH];
	logic [lstlm_pkg::SAMPLE_W-1:0]       samp_hi_q;
	logic [lstlm_pkg::SAMPLE_W-1:0]       samp_lo_q;

	lstlm_pkg::cfg_t                      regs;
	lstlm_pkg::alu_ctrl_t                 alu_ctrl;
	lstlm_pkg::mul_x_t                    alu_x;
	lstlm_pkg::mul_y_t                    alu_y;
	lstlm_pkg::mac_t                      alu_acc;

	logic                                 cmd_take;
	logic [lstlm_pkg::ACCUM_W:0]          sat_sum;
	logic [lstlm_pkg::ACCUM_W-1:0]        acc_inc;
	logic [lstlm_pkg::STEP_W-1:0]         iv_step;
	logic [lstlm_pkg::US_W-1:0]           us;
	logic [lstlm_pkg::ACCUM_W-1:0]        interval;
	logic [lstlm_pkg::ACCUM_W:0]          diff;
	logic                                 acc_ge;
	logic                                 more;
	logic                                 out_free;
	logic [lstlm_pkg::STEP_W-1:0]         rd_hi_addr;
	logic [lstlm_pkg::SAMPLE_W-1:0]       samp_sel;
	logic [lstlm_pkg::WEIGHT_W-1:0]       mix_sel;

	lstlm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lstlm_alu u_alu (
		.clk  (clk),
		.ctrl (alu_ctrl),
		.x    (alu_x),
		.y    (alu_y),
		.acc  (alu_acc)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_take  = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || light.ready;

	assign light.valid      = out_valid_q;
	assign light.step_index = out_step_q;
	assign light.high_light = out_high_q;
	assign light.low_light  = out_low_q;
	assign light.last       = out_last_q;

	// saturating tick add
	always_comb begin
		sat_sum = {1'b0, tick_acc_q} + (lstlm_pkg::ACCUM_W + 1)'(lstlm_pkg::TICK_INCREMENT);
		acc_inc = sat_sum[lstlm_pkg::ACCUM_W] ? '1 : sat_sum[lstlm_pkg::ACCUM_W-1:0];
	end

	// shared interval compare/subtract; in S_EMIT it looks at the next step
	always_comb begin
		iv_step  = (state_q == S_EMIT) ? step_q + 1'b1 : step_q;
		us       = iv_step[lstlm_pkg::HALF_BIT] ? regs.second_half_us : regs.first_half_us;
		if (us == '0) begin
			us = lstlm_pkg::US_W'(1);
		end
		interval = lstlm_pkg::ACCUM_W'({us, {lstlm_pkg::US_TO_TICK_SHIFT{1'b0}}});
		diff     = {1'b0, tick_acc_q} - {1'b0, interval};
		acc_ge   = !diff[lstlm_pkg::ACCUM_W];
		more     = !ext_q && acc_ge &&
			(nsteps_q < lstlm_pkg::STEP_CNT_W'(lstlm_pkg::MAX_STEPS_PER_TICK));
	end

	// ALU operand schedule: per band s*m, t*(32-m), a*d, 255*(32-d)
	always_comb begin
		samp_sel = phase_q[2] ? samp_lo_q : samp_hi_q;
		if (regs.invert) begin
			samp_sel = ~samp_sel;
		end
		mix_sel        = phase_q[2] ? regs.low_mix : regs.high_mix;
		alu_ctrl.en    = (state_q == S_MIX);
		alu_ctrl.clear = !phase_q[0];
		unique case (phase_q[1:0])
			2'd0: begin
				alu_x = lstlm_pkg::mul_x_t'(samp_sel);
				alu_y = lstlm_pkg::mul_y_t'(mix_sel);
			end
			2'd1: begin
				alu_x = lstlm_pkg::mul_x_t'(regs.mix_target);
				alu_y = lstlm_pkg::mul_y_t'(lstlm_pkg::WEIGHT_ONE) -
					lstlm_pkg::mul_y_t'(mix_sel);
			end
			2'd2: begin
				alu_x = lstlm_pkg::mul_x_t'(alu_acc);
				alu_y = lstlm_pkg::mul_y_t'(regs.depth);
			end
			2'd3: begin
				alu_x = lstlm_pkg::mul_x_t'(lstlm_pkg::FULL_LEVEL);
				alu_y = lstlm_pkg::mul_y_t'(lstlm_pkg::WEIGHT_ONE) -
					lstlm_pkg::mul_y_t'(regs.depth);
			end
			default: begin
				alu_x = '0;
				alu_y = '0;
			end
		endcase
	end

	assign rd_hi_addr = step_q + regs.phase_offset;

	always_ff @(posedge clk) begin
		if (cmd_take && lstlm_pkg::op_t'(cmd.op) == lstlm_pkg::OP_TABLE_WR) begin
			store[cmd.table_address] <= cmd.table_value;
		end
		if (state_q == S_RDH) begin
			samp_hi_q <= store[rd_hi_addr];
		end
		if (state_q == S_RDL) begin
			samp_lo_q <= store[step_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tick_acc_q  <= '0;
			step_q      <= '0;
			nsteps_q    <= '0;
			ext_q       <= 1'b0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (light.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						unique case (lstlm_pkg::op_t'(cmd.op))
							lstlm_pkg::OP_TICK: begin
								tick_acc_q <= acc_inc;
								ext_q      <= 1'b0;
								state_q    <= S_CHECK;
							end
							lstlm_pkg::OP_EXT_CLK: begin
								ext_q    <= 1'b1;
								nsteps_q <= lstlm_pkg::STEP_CNT_W'(1);
								state_q  <= S_RDH;
							end
							lstlm_pkg::OP_TABLE_WR: ;
							lstlm_pkg::OP_UNUSED: ;
							default: ;
						endcase
					end
				end
				S_CHECK: begin
					if (acc_ge) begin
						tick_acc_q <= diff[lstlm_pkg::ACCUM_W-1:0];
						nsteps_q   <= lstlm_pkg::STEP_CNT_W'(1);
						state_q    <= S_RDH;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RDH: begin
					state_q <= S_RDL;
				end
				S_RDL: begin
					phase_q <= '0;
					state_q <= S_MIX;
				end
				S_MIX: begin
					if (phase_q == 3'd4) begin
						high_q <= alu_acc[lstlm_pkg::SAMPLE_W-1:0];
					end
					phase_q <= phase_q + 1'b1;
					if (phase_q == 3'd7) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_step_q  <= step_q;
						out_high_q  <= high_q;
						out_low_q   <= alu_acc[lstlm_pkg::SAMPLE_W-1:0];
						out_last_q  <= !more;
						step_q      <= step_q + 1'b1;
						if (more) begin
							tick_acc_q <= diff[lstlm_pkg::ACCUM_W-1:0];
							nsteps_q   <= nsteps_q + 1'b1;
							state_q    <= S_RDH;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: tb/lfo_step_timer_light_mixer_test.sv
`timescale 1ns / 100ps
// Self-checking bench for lfo_step_timer_light_mixer: a typed directed table,
// then random register phases and commands checked against a local predictor.
// Depends on lstlm_pkg, lstlm_if and the block itself.
module lfo_step_timer_light_mixer_test;
	import lstlm_pkg::*;

	localparam int SETTLE_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int NUM_PHASES      = 4;
	localparam int ITEMS_PER_PHASE = 8;
	localparam int MAX_REPORTS     = 200;
	localparam logic [ACCUM_W-1:0] ACC_FULL = '1;

	typedef struct packed {
		logic [STEP_W-1:0]   step_index;
		logic [SAMPLE_W-1:0] high_light;
		logic [SAMPLE_W-1:0] low_light;
		logic                last;
	} light_t;

	typedef enum logic [1:0] {PLAN_CMD, PLAN_LIT, PLAN_CFG} plan_kind_t;

	typedef struct packed {
		plan_kind_t          kind;
		op_t                 op;
		logic [STEP_W-1:0]   addr;
		logic [SAMPLE_W-1:0] value;
		reg_idx_t            idx;
		logic [CFG_DAT_W-1:0] data;
		light_t              lit;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	lstlm_cmd_if   cmd();
	lstlm_light_if light();
	lstlm_cfg_if   cfg();

	lfo_step_timer_light_mixer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.light  (light),
		.cfg    (cfg)
	);

	// predictor state
	cfg_t                mixer_cfg;
	logic [ACCUM_W-1:0]  tick_acc;
	logic [STEP_W-1:0]   wave_step;
	logic [SAMPLE_W-1:0] wave_store [STORE_DEPTH];

	light_t    lights_due[$];
	plan_row_t directed_plan[$];
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        burst_left;
	logic [15:0] ready_pattern = 16'hFFFF;
	int        pattern_age = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [SAMPLE_W-1:0] light_level(input logic [SAMPLE_W-1:0] sample,
		input logic [WEIGHT_W-1:0] weight);
		int s, m, t, d, a;
		s = sample;
		m = weight;
		t = mixer_cfg.mix_target;
		d = mixer_cfg.depth;
		a = (s * m) / WEIGHT_ONE + (t * (WEIGHT_ONE - m)) / WEIGHT_ONE;
		a = (a * d) / WEIGHT_ONE + (FULL_LEVEL * (WEIGHT_ONE - d)) / WEIGHT_ONE;
		return a[SAMPLE_W-1:0];
	endfunction

	function automatic logic [ACCUM_W-1:0] step_interval();
		logic [US_W-1:0] us;
		us = wave_step[HALF_BIT] ? mixer_cfg.second_half_us : mixer_cfg.first_half_us;
		if (us == '0)
			us = US_W'(1);
		return ACCUM_W'(us) << US_TO_TICK_SHIFT;
	endfunction

	function automatic light_t lit_step();
		logic [STEP_W-1:0]   hi_addr;
		logic [SAMPLE_W-1:0] hi_sample, lo_sample;
		light_t              lit;
		hi_addr = wave_step + mixer_cfg.phase_offset;
		hi_sample = wave_store[hi_addr];
		lo_sample = wave_store[wave_step];
		if (mixer_cfg.invert) begin
			hi_sample = SAMPLE_W'(FULL_LEVEL) - hi_sample;
			lo_sample = SAMPLE_W'(FULL_LEVEL) - lo_sample;
		end
		lit = {wave_step, light_level(hi_sample, mixer_cfg.high_mix),
			light_level(lo_sample, mixer_cfg.low_mix), 1'b0};
		wave_step = wave_step + 1'b1;
		return lit;
	endfunction

	function automatic void predict_command(input op_t op, input logic [STEP_W-1:0] addr,
		input logic [SAMPLE_W-1:0] value, output light_t lits[$]);
		lits = {};
		case (op)
		OP_TICK: begin
			if (tick_acc > ACC_FULL - TICK_INCREMENT)
				tick_acc = ACC_FULL;
			else
				tick_acc = tick_acc + TICK_INCREMENT;
			while (lits.size() < MAX_STEPS_PER_TICK && tick_acc >= step_interval()) begin
				tick_acc = tick_acc - step_interval();
				lits.push_back(lit_step());
			end
		end
		OP_EXT_CLK: lits.push_back(lit_step());
		OP_TABLE_WR: wave_store[addr] = value;
		default: ;
		endcase
		if (lits.size() > 0)
			lits[lits.size() - 1].last = 1'b1;
	endfunction

	function automatic void plan_cmd(input op_t op, input logic [STEP_W-1:0] addr,
		input logic [SAMPLE_W-1:0] value);
		plan_row_t row;
		row = '0;
		row.kind = PLAN_CMD;
		row.op = op;
		row.addr = addr;
		row.value = value;
		directed_plan.push_back(row);
	endfunction

	// external clock step whose single light request is known up front
	function automatic void plan_lit(input logic [STEP_W-1:0] step,
		input logic [SAMPLE_W-1:0] hi, input logic [SAMPLE_W-1:0] lo);
		plan_row_t row;
		row = '0;
		row.kind = PLAN_LIT;
		row.op = OP_EXT_CLK;
		row.lit = {step, hi, lo, 1'b1};
		directed_plan.push_back(row);
	endfunction

	function automatic void plan_cfg(input reg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
		plan_row_t row;
		row = '0;
		row.kind = PLAN_CFG;
		row.idx = idx;
		row.data = data;
		directed_plan.push_back(row);
	endfunction

	task automatic flag_mismatch(input string what);
		if (mismatches < MAX_REPORTS)
			$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic send_command(input op_t op, input logic [STEP_W-1:0] addr,
		input logic [SAMPLE_W-1:0] value, input bit typed, input light_t typed_lit);
		light_t lits[$];
		cmd.valid <= 1'b1;
		cmd.op <= op;
		cmd.table_address <= addr;
		cmd.table_value <= value;
		do
			@(posedge clk);
		while (!cmd.ready);
		predict_command(op, addr, value, lits);
		if (typed) begin
			lits.delete();
			lits.push_back(typed_lit);
		end
		foreach (lits[i])
			lights_due.push_back(lits[i]);
		burst_left--;
		if (burst_left <= 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
		end
	endtask

	// registers change only with no light request outstanding
	task automatic quiesce();
		cmd.valid <= 1'b0;
		while (lights_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (idx)
		REG_FIRST_HALF_US: mixer_cfg.first_half_us = data;
		REG_SECOND_HALF_US: mixer_cfg.second_half_us = data;
		REG_PHASE_OFFSET: mixer_cfg.phase_offset = data[STEP_W-1:0];
		REG_INVERT: mixer_cfg.invert = data[0];
		REG_HIGH_MIX: mixer_cfg.high_mix = data[WEIGHT_W-1:0];
		REG_LOW_MIX: mixer_cfg.low_mix = data[WEIGHT_W-1:0];
		REG_MIX_TARGET: mixer_cfg.mix_target = data[SAMPLE_W-1:0];
		default: mixer_cfg.depth = data[WEIGHT_W-1:0];
		endcase
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (pattern_age == 0) begin
			ready_pattern <= ($urandom_range(2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
			pattern_age <= 96;
		end else begin
			ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
			pattern_age <= pattern_age - 1;
		end
		light.ready <= ready_pattern[0];
	end

	always @(posedge clk) begin : light_monitor
		light_t seen, want;
		if (arst_n && light.valid && light.ready) begin
			seen = {light.step_index, light.high_light, light.low_light, light.last};
			if (lights_due.size() == 0) begin
				flag_mismatch($sformatf("light request with none expected, step %0d",
					seen.step_index));
			end else begin
				want = lights_due.pop_front();
				if (seen.step_index !== want.step_index || seen.high_light !== want.high_light
					|| seen.low_light !== want.low_light || seen.last !== want.last)
					flag_mismatch($sformatf(
						"step %0d/%0d high %0d/%0d low %0d/%0d last %0d/%0d (got/want)",
						seen.step_index, want.step_index, seen.high_light, want.high_light,
						seen.low_light, want.low_light, seen.last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd.valid && cmd.ready) || (light.valid && light.ready)
				|| (cfg.valid && cfg.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int                   k;
		op_t                  op;
		logic [CFG_DAT_W-1:0] data;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.op = OP_TICK;
		cmd.table_address = '0;
		cmd.table_value = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_FIRST_HALF_US;
		cfg.data = '0;
		mixer_cfg = {FIRST_HALF_RST, SECOND_HALF_RST, PHASE_RST, INVERT_RST,
			HIGH_MIX_RST, LOW_MIX_RST, TARGET_RST, DEPTH_RST};
		tick_acc = '0;
		wave_step = '0;
		burst_left = $urandom_range(1, 6);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ramp fill: every entry written, sample equals address
		for (int a = 0; a < STORE_DEPTH; a++)
			send_command(OP_TABLE_WR, STEP_W'(a), SAMPLE_W'(a), 1'b0, '0);

		plan_lit(8'd0, 8'd0, 8'd0);
		plan_lit(8'd1, 8'd1, 8'd1);
		plan_cmd(OP_UNUSED, 8'hFF, 8'hFF);
		plan_lit(8'd2, 8'd2, 8'd2);
		plan_cmd(OP_TICK, 8'h00, 8'h00);
		plan_cmd(OP_TABLE_WR, 8'd3, 8'hA5);
		plan_lit(8'd3, 8'hA5, 8'hA5);
		plan_cfg(REG_DEPTH, 24'd0);
		plan_lit(8'd4, 8'd255, 8'd255);
		plan_cfg(REG_PHASE_OFFSET, 24'd255);
		plan_cfg(REG_DEPTH, 24'd32);
		plan_lit(8'd5, 8'd4, 8'd5);
		plan_cfg(REG_INVERT, 24'd1);
		plan_lit(8'd6, 8'd250, 8'd249);
		plan_cfg(REG_DEPTH, 24'd63);
		plan_cmd(OP_EXT_CLK, 8'h00, 8'h00);
		plan_cfg(REG_HIGH_MIX, 24'd63);
		plan_cfg(REG_LOW_MIX, 24'd0);
		plan_cfg(REG_MIX_TARGET, 24'd255);
		plan_cfg(REG_DEPTH, 24'd32);
		plan_cmd(OP_EXT_CLK, 8'h00, 8'h00);
		// zero interval counts as one: four steps per tick, surplus carried
		plan_cfg(REG_FIRST_HALF_US, 24'd0);
		plan_cfg(REG_SECOND_HALF_US, 24'd0);
		plan_cmd(OP_TICK, 8'h00, 8'h00);
		plan_cmd(OP_TICK, 8'h00, 8'h00);
		plan_cfg(REG_FIRST_HALF_US, 24'hFFFFFF);
		plan_cfg(REG_SECOND_HALF_US, 24'hFFFFFF);
		plan_cmd(OP_TICK, 8'h00, 8'h00);
		plan_cmd(OP_EXT_CLK, 8'h00, 8'h00);

		foreach (directed_plan[i]) begin
			case (directed_plan[i].kind)
			PLAN_CFG: begin
				quiesce();
				write_register(directed_plan[i].idx, directed_plan[i].data);
			end
			PLAN_LIT: send_command(OP_EXT_CLK, '0, '0, 1'b1, directed_plan[i].lit);
			default: send_command(directed_plan[i].op, directed_plan[i].addr,
				directed_plan[i].value, 1'b0, '0);
			endcase
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			quiesce();
			for (int r = 0; r < 8; r++) begin
				case (reg_idx_t'(r))
				REG_FIRST_HALF_US, REG_SECOND_HALF_US: begin
					case ($urandom_range(7))
					0: data = '0;
					1: data = 24'hFFFFFF;
					2: data = CFG_DAT_W'($urandom);
					default: data = CFG_DAT_W'($urandom_range(1, 40));
					endcase
				end
				REG_PHASE_OFFSET, REG_MIX_TARGET: data = CFG_DAT_W'($urandom_range(255));
				REG_INVERT: data = CFG_DAT_W'($urandom_range(1));
				default: data = ($urandom_range(3) == 0) ? CFG_DAT_W'($urandom_range(63))
					: CFG_DAT_W'($urandom_range(32));
				endcase
				write_register(reg_idx_t'(r), data);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				k = $urandom_range(99);
				op = (k < 48) ? OP_TICK : (k < 70) ? OP_EXT_CLK : (k < 95) ? OP_TABLE_WR : OP_UNUSED;
				send_command(op, STEP_W'($urandom), SAMPLE_W'($urandom), 1'b0, '0);
			end
		end

		quiesce();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
